[rtl/qvr_pkg.sv]
// Shared constants, types and stage indexes for the quaternion vector rotator.
package qvr_pkg;

    // Fraction bits of the quaternion components (16384 is one at 14).
    localparam int FRAC_BITS = 14;

    // Field widths of the request and result items.
    localparam int QW = 16;
    localparam int VW = 16;

    // Pair product: 16-bit component times a doubled 17-bit component.
    localparam int PAIR_W  = 2 * QW + 1;

    // Matrix entry: a sum or difference of two pair products, or one minus such a sum.
    localparam int ENTRY_BASE_W = (2 * FRAC_BITS + 2 > PAIR_W + 1) ?
                                  (2 * FRAC_BITS + 2) : (PAIR_W + 1);
    localparam int ENTRY_W = ENTRY_BASE_W + 1;

    // Entry times vector component, and the sum of three with the rounding term.
    localparam int PROD_W = ENTRY_W + VW;
    localparam int SUM_W  = PROD_W + 2;

    // Bit positions of the rounded result inside the sum.
    localparam int RES_LO = 2 * FRAC_BITS;
    localparam int RES_HI = 2 * FRAC_BITS + VW - 1;

    // Pipeline stages.
    localparam int NSTAGE   = 5;
    localparam int ST_PAIR  = 0;
    localparam int ST_ENTRY = 1;
    localparam int ST_MUL   = 2;
    localparam int ST_SUM   = 3;
    localparam int ST_OUT   = 4;

    typedef logic signed [QW-1:0]      qvr_quat_t;
    typedef logic signed [VW-1:0]      qvr_vec_t;
    typedef logic signed [PAIR_W-1:0]  qvr_pair_t;
    typedef logic signed [ENTRY_W-1:0] qvr_entry_t;
    typedef logic signed [PROD_W-1:0]  qvr_prod_t;
    typedef logic signed [SUM_W-1:0]   qvr_sum_t;

    // Per-stage load strobes handed from the pipeline control to the datapath.
    typedef struct packed {
        logic [NSTAGE-1:0] ld;
    } qvr_ctl_t;

endpackage

[rtl/qvr_if.sv]
// Request channel: one quaternion and one vector.
interface qvr_in_if;
    logic             valid;
    logic             ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;

    modport source
    (
        output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink
    (
        input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

// Result channel: the rotated vector and the saturation flag.
interface qvr_out_if;
    logic             valid;
    logic             ready;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic             clipped;

    modport source
    (
        output valid, rot_x, rot_y, rot_z, clipped,
        input  ready
    );

    modport sink
    (
        input  valid, rot_x, rot_y, rot_z, clipped,
        output ready
    );
endinterface

[rtl/qvr_matrix.sv]
// Builds the 3x3 rotation matrix from the quaternion in two stages and
// carries the vector alongside it.
module qvr_matrix
(
    input  logic                clk,
    input  qvr_pkg::qvr_ctl_t   ctl,
    input  qvr_pkg::qvr_quat_t  quat_w,
    input  qvr_pkg::qvr_quat_t  quat_x,
    input  qvr_pkg::qvr_quat_t  quat_y,
    input  qvr_pkg::qvr_quat_t  quat_z,
    input  qvr_pkg::qvr_vec_t   vec_in [3],
    output qvr_pkg::qvr_entry_t ent [3][3],
    output qvr_pkg::qvr_vec_t   vec_out [3]
);

    localparam qvr_pkg::qvr_entry_t ONE =
        qvr_pkg::ENTRY_W'(1) <<< (2 * qvr_pkg::FRAC_BITS);

    logic signed [qvr_pkg::QW:0] dx, dy, dz;

    qvr_pkg::qvr_pair_t xx_reg, yy_reg, zz_reg;
    qvr_pkg::qvr_pair_t xy_reg, xz_reg, yz_reg;
    qvr_pkg::qvr_pair_t wx_reg, wy_reg, wz_reg;
    qvr_pkg::qvr_vec_t  vec1_reg [3];

    qvr_pkg::qvr_entry_t ent_reg  [3][3];
    qvr_pkg::qvr_entry_t ent_next [3][3];
    qvr_pkg::qvr_vec_t   vec2_reg [3];

    // Doubled vector part of the quaternion.
    assign dx = {quat_x, 1'b0};
    assign dy = {quat_y, 1'b0};
    assign dz = {quat_z, 1'b0};

    // First stage: the nine pair products.
    always_ff @(posedge clk)
    begin
        if (ctl.ld[qvr_pkg::ST_PAIR])
        begin
            xx_reg <= qvr_pkg::PAIR_W'(quat_x) * qvr_pkg::PAIR_W'(dx);
            yy_reg <= qvr_pkg::PAIR_W'(quat_y) * qvr_pkg::PAIR_W'(dy);
            zz_reg <= qvr_pkg::PAIR_W'(quat_z) * qvr_pkg::PAIR_W'(dz);
            xy_reg <= qvr_pkg::PAIR_W'(quat_x) * qvr_pkg::PAIR_W'(dy);
            xz_reg <= qvr_pkg::PAIR_W'(quat_x) * qvr_pkg::PAIR_W'(dz);
            yz_reg <= qvr_pkg::PAIR_W'(quat_y) * qvr_pkg::PAIR_W'(dz);
            wx_reg <= qvr_pkg::PAIR_W'(quat_w) * qvr_pkg::PAIR_W'(dx);
            wy_reg <= qvr_pkg::PAIR_W'(quat_w) * qvr_pkg::PAIR_W'(dy);
            wz_reg <= qvr_pkg::PAIR_W'(quat_w) * qvr_pkg::PAIR_W'(dz);
            vec1_reg <= vec_in;
        end
    end

    // Matrix entries from the pair products.
    always_comb
    begin
        ent_next[0][0] = ONE - (qvr_pkg::ENTRY_W'(yy_reg) + qvr_pkg::ENTRY_W'(zz_reg));
        ent_next[0][1] = qvr_pkg::ENTRY_W'(xy_reg) - qvr_pkg::ENTRY_W'(wz_reg);
        ent_next[0][2] = qvr_pkg::ENTRY_W'(xz_reg) + qvr_pkg::ENTRY_W'(wy_reg);
        ent_next[1][0] = qvr_pkg::ENTRY_W'(xy_reg) + qvr_pkg::ENTRY_W'(wz_reg);
        ent_next[1][1] = ONE - (qvr_pkg::ENTRY_W'(xx_reg) + qvr_pkg::ENTRY_W'(zz_reg));
        ent_next[1][2] = qvr_pkg::ENTRY_W'(yz_reg) - qvr_pkg::ENTRY_W'(wx_reg);
        ent_next[2][0] = qvr_pkg::ENTRY_W'(xz_reg) - qvr_pkg::ENTRY_W'(wy_reg);
        ent_next[2][1] = qvr_pkg::ENTRY_W'(yz_reg) + qvr_pkg::ENTRY_W'(wx_reg);
        ent_next[2][2] = ONE - (qvr_pkg::ENTRY_W'(xx_reg) + qvr_pkg::ENTRY_W'(yy_reg));
    end

    // Second stage: register the matrix.
    always_ff @(posedge clk)
    begin
        if (ctl.ld[qvr_pkg::ST_ENTRY])
        begin
            ent_reg  <= ent_next;
            vec2_reg <= vec1_reg;
        end
    end

    assign ent     = ent_reg;
    assign vec_out = vec2_reg;

endmodule

[rtl/qvr_dot.sv]
// One matrix row times the vector: multiply, sum with rounding, then
// shift down and saturate, one register stage each.
module qvr_dot
(
    input  logic                clk,
    input  qvr_pkg::qvr_ctl_t   ctl,
    input  qvr_pkg::qvr_entry_t row [3],
    input  qvr_pkg::qvr_vec_t   vec [3],
    output qvr_pkg::qvr_vec_t   rot,
    output logic                sat
);

    localparam qvr_pkg::qvr_sum_t HALF =
        qvr_pkg::SUM_W'(1) <<< (2 * qvr_pkg::FRAC_BITS - 1);

    qvr_pkg::qvr_prod_t prod_reg [3];
    qvr_pkg::qvr_sum_t  sum_reg;
    qvr_pkg::qvr_sum_t  sum_next;
    qvr_pkg::qvr_vec_t  rot_reg, rot_next;
    logic               sat_reg, sat_next;
    logic [qvr_pkg::SUM_W-1-qvr_pkg::RES_HI:0] top_bits;

    // Entry times vector component.
    always_ff @(posedge clk)
    begin
        if (ctl.ld[qvr_pkg::ST_MUL])
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[j] <= qvr_pkg::PROD_W'(row[j]) * qvr_pkg::PROD_W'(vec[j]);
            end
        end
    end

    // Exact sum of the three products plus one half of the output step.
    assign sum_next = qvr_pkg::SUM_W'(prod_reg[0]) + qvr_pkg::SUM_W'(prod_reg[1])
                    + qvr_pkg::SUM_W'(prod_reg[2]) + HALF;

    always_ff @(posedge clk)
    begin
        if (ctl.ld[qvr_pkg::ST_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    // The rounded result fits when all bits above it match its sign bit.
    assign top_bits = sum_reg[qvr_pkg::SUM_W-1:qvr_pkg::RES_HI];

    always_comb
    begin
        if ((top_bits == '0) || (top_bits == '1))
        begin
            rot_next = sum_reg[qvr_pkg::RES_HI:qvr_pkg::RES_LO];
            sat_next = 1'b0;
        end
        else if (sum_reg[qvr_pkg::SUM_W-1])
        begin
            rot_next = {1'b1, {(qvr_pkg::VW-1){1'b0}}};
            sat_next = 1'b1;
        end
        else
        begin
            rot_next = {1'b0, {(qvr_pkg::VW-1){1'b1}}};
            sat_next = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (ctl.ld[qvr_pkg::ST_OUT])
        begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign rot = rot_reg;
    assign sat = sat_reg;

endmodule

[rtl/quaternion_vector_rotate.sv]
// Quaternion vector rotation, five-stage pipeline.
// An accepted request passes the pair, entry, multiply, sum and output stages in turn.
// Throughput: one request per cycle while result.ready is high; each stage holds its item
// while the next is full, and a bubble ahead of a stall is filled, so requests keep flowing.
// Reset (rst_n low, asynchronous) empties the pipeline; the data registers are not reset.
module quaternion_vector_rotate
(
    input  logic      clk,
    input  logic      rst_n,
    qvr_in_if.sink    item,
    qvr_out_if.source result
);

    logic [qvr_pkg::NSTAGE-1:0] valid_reg, valid_next;
    logic [qvr_pkg::NSTAGE-1:0] stage_ready;
    logic [qvr_pkg::NSTAGE-1:0] prev_valid;
    qvr_pkg::qvr_ctl_t          ctl;

    qvr_pkg::qvr_vec_t   vec_in  [3];
    qvr_pkg::qvr_vec_t   vec_m   [3];
    qvr_pkg::qvr_entry_t ent     [3][3];
    qvr_pkg::qvr_vec_t   rot     [3];
    logic [2:0]          sat;

    // A stage can take an item when it is empty or its content moves on.
    always_comb
    begin
        stage_ready[qvr_pkg::NSTAGE-1] = !valid_reg[qvr_pkg::NSTAGE-1] || result.ready;
        for (int k = qvr_pkg::NSTAGE - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign prev_valid = {valid_reg[qvr_pkg::NSTAGE-2:0], item.valid};
    assign ctl.ld     = stage_ready & prev_valid;

    always_comb
    begin
        for (int k = 0; k < qvr_pkg::NSTAGE; k++)
        begin
            valid_next[k] = stage_ready[k] ? prev_valid[k] : valid_reg[k];
        end
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign item.ready = stage_ready[0];

    assign vec_in[0] = item.vec_x;
    assign vec_in[1] = item.vec_y;
    assign vec_in[2] = item.vec_z;

    // Matrix construction.
    qvr_matrix u_matrix
    (
        .clk     (clk),
        .ctl     (ctl),
        .quat_w  (item.quat_w),
        .quat_x  (item.quat_x),
        .quat_y  (item.quat_y),
        .quat_z  (item.quat_z),
        .vec_in  (vec_in),
        .ent     (ent),
        .vec_out (vec_m)
    );

    // One dot product per output component.
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        qvr_dot u_dot
        (
            .clk (clk),
            .ctl (ctl),
            .row (ent[r]),
            .vec (vec_m),
            .rot (rot[r]),
            .sat (sat[r])
        );
    end

    assign result.valid   = valid_reg[qvr_pkg::ST_OUT];
    assign result.rot_x   = rot[0];
    assign result.rot_y   = rot[1];
    assign result.rot_z   = rot[2];
    assign result.clipped = |sat;

endmodule

[sim/qvr_rotate_checker.sv]
module qvr_rotate_checker
(
    input  logic clk,
    input  logic rst_n,
    qvr_in_if    item,
    qvr_out_if   result,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        qvr_pkg::qvr_vec_t x;
        qvr_pkg::qvr_vec_t y;
        qvr_pkg::qvr_vec_t z;
        logic              clipped;
    } rotated_vec_t;

    rotated_vec_t rotated_q[$];
    int           fail_cnt = 0;

    assign errors = fail_cnt;

    // Rotate one vector by the expanded matrix of one quaternion.
    // Entries and dot products are exact; each sum is rounded half up once and saturated.
    function automatic rotated_vec_t rotate_vector(qvr_pkg::qvr_quat_t qw,
                                                   qvr_pkg::qvr_quat_t qx,
                                                   qvr_pkg::qvr_quat_t qy,
                                                   qvr_pkg::qvr_quat_t qz,
                                                   qvr_pkg::qvr_vec_t vx,
                                                   qvr_pkg::qvr_vec_t vy,
                                                   qvr_pkg::qvr_vec_t vz);
        longint       w, x, y, z;
        longint       dx, dy, dz;
        longint       xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint       unity;
        longint       m [3][3];
        longint       v [3];
        longint       acc;
        longint       res [3];
        rotated_vec_t r;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        dx = 2 * x;
        dy = 2 * y;
        dz = 2 * z;
        xx = x * dx;
        yy = y * dy;
        zz = z * dz;
        xy = x * dy;
        xz = x * dz;
        yz = y * dz;
        wx = w * dx;
        wy = w * dy;
        wz = w * dz;
        unity = longint'(1) << (2 * qvr_pkg::FRAC_BITS);
        m[0][0] = unity - (yy + zz);
        m[0][1] = xy - wz;
        m[0][2] = xz + wy;
        m[1][0] = xy + wz;
        m[1][1] = unity - (xx + zz);
        m[1][2] = yz - wx;
        m[2][0] = xz - wy;
        m[2][1] = yz + wx;
        m[2][2] = unity - (xx + yy);
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        r.clipped = 1'b0;
        for (int row = 0; row < 3; row++)
        begin
            acc = longint'(1) << (2 * qvr_pkg::FRAC_BITS - 1);
            for (int col = 0; col < 3; col++)
            begin
                acc += m[row][col] * v[col];
            end
            // Arithmetic shift of a signed value is a floor division.
            acc = acc >>> (2 * qvr_pkg::FRAC_BITS);
            if (acc > 32767)
            begin
                acc = 32767;
                r.clipped = 1'b1;
            end
            else if (acc < -32768)
            begin
                acc = -32768;
                r.clipped = 1'b1;
            end
            res[row] = acc;
        end
        r.x = qvr_pkg::qvr_vec_t'(res[0]);
        r.y = qvr_pkg::qvr_vec_t'(res[1]);
        r.z = qvr_pkg::qvr_vec_t'(res[2]);
        return r;
    endfunction

    // Compare each returned vector with the oldest prediction, then predict for a new request.
    always @(posedge clk or negedge rst_n)
    begin
        rotated_vec_t want;
        rotated_vec_t got;
        if (!rst_n)
        begin
            rotated_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.x = result.rot_x;
                got.y = result.rot_y;
                got.z = result.rot_z;
                got.clipped = result.clipped;
                if (rotated_q.size() == 0)
                begin
                    if (fail_cnt < REPORT_LIMIT)
                        $display("%0t: unexpected result x=%0d y=%0d z=%0d clipped=%0b",
                                 $realtime, got.x, got.y, got.z, got.clipped);
                    fail_cnt++;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.clipped !== want.clipped)
                    begin
                        if (fail_cnt < REPORT_LIMIT)
                            $display("%0t: mismatch expected x=%0d y=%0d z=%0d clipped=%0b, %s",
                                     $realtime, want.x, want.y, want.z, want.clipped,
                                     $sformatf("got x=%0d y=%0d z=%0d clipped=%0b",
                                               got.x, got.y, got.z, got.clipped));
                        fail_cnt++;
                    end
                end
            end
            if (item.valid && item.ready)
                rotated_q.push_back(rotate_vector(item.quat_w, item.quat_x, item.quat_y,
                                                  item.quat_z, item.vec_x, item.vec_y,
                                                  item.vec_z));
            outstanding <= rotated_q.size();
        end
    end

endmodule

[sim/tb_quaternion_vector_rotate.sv]
module tb_quaternion_vector_rotate;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT_ITEM = 300;
    localparam int DRAIN_CYCLES = 2 * qvr_pkg::NSTAGE + 10;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct {
        qvr_pkg::qvr_quat_t w;
        qvr_pkg::qvr_quat_t x;
        qvr_pkg::qvr_quat_t y;
        qvr_pkg::qvr_quat_t z;
        qvr_pkg::qvr_vec_t  vx;
        qvr_pkg::qvr_vec_t  vy;
        qvr_pkg::qvr_vec_t  vz;
    } rotate_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   hold_off_req = 1'b0;
    bit   send_gaps_on = 1'b1;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;

    qvr_in_if  req_ch();
    qvr_out_if res_ch();

    quaternion_vector_rotate DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .result (res_ch)
    );

    qvr_rotate_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (req_ch),
        .result      (res_ch),
        .errors      (fail_count),
        .outstanding (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] corner_word();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            5:       return 16'h4000;
            default: return 16'hC000;
        endcase
    endfunction

    function automatic real rand_signed_unit();
        return (real'(int'($urandom_range(0, 65535))) - 32768.0) / 32768.0;
    endfunction

    // Half of the requests carry a unit quaternion, the rest raw or corner components.
    function automatic rotate_req_t make_random_req();
        rotate_req_t r;
        int          kind;
        real         a, b, c, d, norm;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            a = rand_signed_unit();
            b = rand_signed_unit();
            c = rand_signed_unit();
            d = rand_signed_unit();
            norm = $sqrt(a * a + b * b + c * c + d * d);
            if (norm < 0.01)
            begin
                a = 1.0;
                norm = 1.0;
            end
            r.w = qvr_pkg::qvr_quat_t'(int'(a / norm * 16384.0));
            r.x = qvr_pkg::qvr_quat_t'(int'(b / norm * 16384.0));
            r.y = qvr_pkg::qvr_quat_t'(int'(c / norm * 16384.0));
            r.z = qvr_pkg::qvr_quat_t'(int'(d / norm * 16384.0));
        end
        else if (kind < 8)
        begin
            r.w = qvr_pkg::qvr_quat_t'($urandom_range(0, 65535));
            r.x = qvr_pkg::qvr_quat_t'($urandom_range(0, 65535));
            r.y = qvr_pkg::qvr_quat_t'($urandom_range(0, 65535));
            r.z = qvr_pkg::qvr_quat_t'($urandom_range(0, 65535));
        end
        else
        begin
            r.w = corner_word();
            r.x = corner_word();
            r.y = corner_word();
            r.z = corner_word();
        end
        if ($urandom_range(0, 7) == 0)
        begin
            r.vx = corner_word();
            r.vy = corner_word();
            r.vz = corner_word();
        end
        else
        begin
            r.vx = qvr_pkg::qvr_vec_t'($urandom_range(0, 65535));
            r.vy = qvr_pkg::qvr_vec_t'($urandom_range(0, 65535));
            r.vz = qvr_pkg::qvr_vec_t'($urandom_range(0, 65535));
        end
        return r;
    endfunction

    // Offer one request after an optional gap and hold it until it is taken.
    task automatic send_request(input rotate_req_t r);
        int gap;
        gap = send_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.quat_w <= r.w;
        req_ch.quat_x <= r.x;
        req_ch.quat_y <= r.y;
        req_ch.quat_z <= r.z;
        req_ch.vec_x  <= r.vx;
        req_ch.vec_y  <= r.vy;
        req_ch.vec_z  <= r.vz;
        req_ch.valid  <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Result side: random ready pattern, plus one long hold-off while requests keep coming.
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // Abort if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("quaternion_vector_rotate regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Request stimulus and verdict.
    initial
    begin
        req_ch.valid  = 1'b0;
        req_ch.quat_w = '0;
        req_ch.quat_x = '0;
        req_ch.quat_y = '0;
        req_ch.quat_z = '0;
        req_ch.vec_x  = '0;
        req_ch.vec_y  = '0;
        req_ch.vec_z  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity, zero quaternion and vector extremes.
        send_request('{16384, 0, 0, 0, 1000, -2000, 3000});
        send_request('{16384, 0, 0, 0, 32767, -32768, 0});
        send_request('{-16384, 0, 0, 0, -32768, 32767, -1});
        send_request('{0, 0, 0, 0, 32767, -32768, 12345});
        // Quarter turns about each axis and half turns that push past full scale.
        send_request('{11585, 0, 0, 11585, 10000, 0, 0});
        send_request('{11585, 11585, 0, 0, 0, 10000, -5000});
        send_request('{11585, 0, 11585, 0, 7000, -3000, 10000});
        send_request('{0, 16384, 0, 0, -32768, -32768, -32768});
        send_request('{0, 0, 16384, 0, 32767, 32767, 32767});
        send_request('{0, -32768, 0, 0, 0, 0, 1});
        // Exact halves: ties must round toward plus infinity.
        send_request('{0, 0, 0, 8192, 1, -1, 3});
        send_request('{0, 0, 0, 8192, -3, 3, 0});
        // Quaternions far from unit length, most of them saturating.
        send_request('{32767, 32767, 32767, 32767, 32767, 32767, 32767});
        send_request('{-32768, -32768, -32768, -32768, -32768, -32768, -32768});
        send_request('{-32768, 32767, -32768, 32767, 32767, -32768, 32767});
        send_request('{0, 32767, 0, 0, 100, 100, 100});
        send_request('{16384, 16384, 16384, 16384, -32768, 32767, -32768});
        send_request('{8192, 0, 0, 0, 20000, -20000, 5});
        send_request('{1, 1, 1, 1, 1, 1, 1});
        send_request('{-1, -1, -1, -1, -1, -1, -1});

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                send_gaps_on = ($urandom_range(0, 2) != 0);
            if (i == HOLD_AT_ITEM)
                hold_off_req = 1'b1;
            send_request(make_random_req());
        end
        req_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("quaternion_vector_rotate regression: pass");
        else
            $display("quaternion_vector_rotate regression: fail");
        $finish;
    end

endmodule
